@@ design/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg
// Types and constants shared by the text console cursor engine modules.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int MAX_PREFIX = 8;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_SET = 1'b1;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  localparam logic [7:0] CODE_BACKSPACE = 8'h08;
  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] CODE_SPACE     = 8'h20;

  localparam logic [1:0] CFG_COLUMNS       = 2'd0;
  localparam logic [1:0] CFG_ROWS          = 2'd1;
  localparam logic [1:0] CFG_PREFIX_LENGTH = 2'd2;
  localparam logic [1:0] CFG_PREFIX_CHARS  = 2'd3;

  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [7:0] RESET_ROWS    = 8'd25;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [7:0] set_column;
    logic [7:0] set_row;
  } req_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] cell_column;
    logic [7:0] cell_row;
    logic [7:0] glyph;
    logic       last;
  } rsp_item_t;

  typedef struct packed {
    logic [7:0]  columns;
    logic [7:0]  rows;
    logic [3:0]  prefix_length;
    logic [63:0] prefix_chars;
  } cfg_t;

  // One classified request: an optional draw, an optional scroll, then a
  // run of prefix draws on one row.
  typedef struct packed {
    logic       has_draw;
    logic [7:0] draw_column;
    logic [7:0] draw_row;
    logic [7:0] draw_glyph;
    logic       has_scroll;
    logic [3:0] prefix_count;
    logic [7:0] prefix_row;
  } job_t;

endpackage

@@ design/tcce_front.sv @@
// ----------------------------------------------------------------------------
// tcce_front
// Owns the cursor; classifies each request into at most one job descriptor.
// ----------------------------------------------------------------------------
module tcce_front
  import tcce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      accept,
  input  req_item_t req_item,
  output logic      push,
  output job_t      job
);

  logic [7:0] cursor_column, cursor_column_next;
  logic [7:0] cursor_row, cursor_row_next;

  logic [3:0] limit;
  logic [7:0] limit8;
  logic [8:0] col_inc;
  logic [8:0] row_inc;
  logic       col_wrap;
  logic       row_hit;
  logic [7:0] nl_row;
  logic       job_valid;

  always_comb begin
    limit    = (cfg.prefix_length > 4'(MAX_PREFIX)) ? 4'(MAX_PREFIX) : cfg.prefix_length;
    limit8   = {4'b0, limit};
    col_inc  = {1'b0, cursor_column} + 9'd1;
    row_inc  = {1'b0, cursor_row} + 9'd1;
    col_wrap = col_inc >= {1'b0, cfg.columns};
    row_hit  = row_inc >= {1'b0, cfg.rows};
    nl_row   = row_hit ? cursor_row : row_inc[7:0];

    job                = '0;
    job.draw_row       = cursor_row;
    job.prefix_row     = nl_row;
    job_valid          = 1'b0;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;

    if (req_item.cmd == CMD_SET) begin
      cursor_column_next = req_item.set_column;
      cursor_row_next    = req_item.set_row;
    end else begin
      unique case (req_item.char_code)
        CODE_NEWLINE: begin
          job.has_scroll     = row_hit;
          job.prefix_count   = limit;
          job_valid          = row_hit || (limit != 4'd0);
          cursor_column_next = limit8;
          cursor_row_next    = nl_row;
        end
        CODE_BACKSPACE: begin
          if (cursor_column > limit8) begin
            job.has_draw    = 1'b1;
            job.draw_column = cursor_column - 8'd1;
            job.draw_glyph  = CODE_SPACE;
            job_valid       = 1'b1;
            if (cursor_column >= cfg.columns) begin
              job.has_scroll     = row_hit;
              job.prefix_count   = limit;
              cursor_column_next = limit8 - 8'd1;
              cursor_row_next    = nl_row;
            end else begin
              cursor_column_next = cursor_column - 8'd1;
            end
          end
        end
        default: begin
          job.has_draw    = 1'b1;
          job.draw_column = cursor_column;
          job.draw_glyph  = req_item.char_code;
          job_valid       = 1'b1;
          if (col_wrap) begin
            job.has_scroll     = row_hit;
            job.prefix_count   = limit;
            cursor_column_next = limit8;
            cursor_row_next    = nl_row;
          end else begin
            cursor_column_next = col_inc[7:0];
          end
        end
      endcase
    end

    push = accept && job_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

@@ design/tcce_queue.sv @@
// ----------------------------------------------------------------------------
// tcce_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module tcce_queue
  import tcce_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/tcce_back.sv @@
// ----------------------------------------------------------------------------
// tcce_back
// Expands the head job into screen operations, one per cycle unless stalled by rsp_ready.
// ----------------------------------------------------------------------------
module tcce_back
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] prefix_chars,
  input  logic        head_valid,
  input  job_t        head,
  output logic        pop,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp_item
);

  logic [3:0] step;
  logic [3:0] total;
  logic [3:0] after_draw;
  logic [3:0] prefix_pos;
  logic [2:0] idx;
  logic       load;
  rsp_item_t  next_item;

  always_comb begin
    total      = {3'b0, head.has_draw} + {3'b0, head.has_scroll} + head.prefix_count;
    after_draw = step - {3'b0, head.has_draw};
    prefix_pos = after_draw - {3'b0, head.has_scroll};
    idx        = prefix_pos[2:0];
    next_item  = '0;
    if (head.has_draw && step == 4'd0) begin
      next_item.kind        = KIND_DRAW;
      next_item.cell_column = head.draw_column;
      next_item.cell_row    = head.draw_row;
      next_item.glyph       = head.draw_glyph;
    end else if (head.has_scroll && after_draw == 4'd0) begin
      next_item.kind = KIND_SCROLL;
    end else begin
      next_item.kind        = KIND_DRAW;
      next_item.cell_column = {5'b0, idx};
      next_item.cell_row    = head.prefix_row;
      next_item.glyph       = prefix_chars[{idx, 3'b000} +: 8];
    end
    next_item.last = step == (total - 4'd1);
    load = head_valid && (!rsp_valid || rsp_ready);
    pop  = load && next_item.last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_item <= next_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
        step      <= next_item.last ? 4'd0 : step + 4'd1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/text_console_cursor_engine.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text cursor control: turns character and set-cursor requests into draw
// and scroll operations.
// ----------------------------------------------------------------------------
// Order: a request's job is written into the queue at acceptance, and its
// operations are then loaded from the queue head into the output register.
// Throughput: one request per cycle while the job queue has room; the back
// sequencer emits one operation per cycle unless stalled by rsp_ready, and a
// request's job holds its queue slot until its last operation is loaded.
// Reset (rst, synchronous): cursor to 0,0, registers to 80 columns, 25 rows,
// empty prefix; queue and output register emptied.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_item_t   req_item,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp_item
);

  cfg_t cfg;
  logic accept;
  logic push;
  job_t push_job;
  logic full;
  logic pop;
  logic head_valid;
  job_t head;

  // Configuration registers; the user must write them only while the engine is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns       <= RESET_COLUMNS;
      cfg.rows          <= RESET_ROWS;
      cfg.prefix_length <= '0;
      cfg.prefix_chars  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COLUMNS:       cfg.columns       <= cfg_data[7:0];
        CFG_ROWS:          cfg.rows          <= cfg_data[7:0];
        CFG_PREFIX_LENGTH: cfg.prefix_length <= cfg_data[3:0];
        CFG_PREFIX_CHARS:  cfg.prefix_chars  <= cfg_data;
        default:           cfg               <= cfg;
      endcase
    end
  end

  // Take a request whenever the queue can hold its job; the cursor moves at
  // acceptance, so the front waits on the back only when the queue is full.
  assign req_ready = !full;
  assign accept    = req_valid && req_ready;

  tcce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .req_item (req_item),
    .push     (push),
    .job      (push_job)
  );

  // Buffer classified jobs so that long prefix runs drain on their own.
  tcce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Expand the head job and hold each operation until it is taken.
  tcce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .prefix_chars (cfg.prefix_chars),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp_item     (rsp_item)
  );

`ifndef SYNTHESIS
  // A pending operation that is not the last one leaves its job in the queue.
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_item.last) |-> head_valid)
    else $error("job left the queue before its last operation");

  // A set-cursor request never creates a job.
  a_set_no_job: assert property (@(posedge clk) disable iff (rst)
    (accept && req_item.cmd == CMD_SET) |-> !push)
    else $error("set-cursor request queued a job");

  // Only a present job can be retired.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  // A new job always lands in a queue with room.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");
`endif

endmodule
